/* hdl/dts_pkg.sv */
// ----------------------------------------------------------------------------
// dts_pkg
// shared types and constants of the depth-first topological sorter
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int VTX_W = 6;
  localparam int POS_W = 7;
  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] VC_RESET = 7'd64;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_GRAY  = 2'd1;
  localparam logic [1:0] COL_BLACK = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_STEP,
    ST_POP,
    ST_EDGE,
    ST_COLOR,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] vertex_position;
    logic             is_last;
    logic             has_cycle;
    logic             edge_dropped;
  } result_t;

endpackage

/* hdl/dts_if.sv */
// ----------------------------------------------------------------------------
// dts_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface dts_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [dts_pkg::VTX_W-1:0] from_vertex;
  logic [dts_pkg::VTX_W-1:0] to_vertex;

  modport source (output valid, kind, from_vertex, to_vertex, input ready);
  modport sink (input valid, kind, from_vertex, to_vertex, output ready);
endinterface

interface dts_out_if;
  logic                      valid;
  logic                      ready;
  logic [dts_pkg::POS_W-1:0] vertex_position;
  logic                      is_last;
  logic                      has_cycle;
  logic                      edge_dropped;

  modport source (output valid, vertex_position, is_last, has_cycle, edge_dropped,
                  input ready);
  modport sink (input valid, vertex_position, is_last, has_cycle, edge_dropped,
                output ready);
endinterface

/* hdl/dts_ram.sv */
// ----------------------------------------------------------------------------
// dts_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/dts_engine.sv */
// ----------------------------------------------------------------------------
// dts_engine
// edge list build, stack-based depth-first walk and rank readout
// ----------------------------------------------------------------------------
module dts_engine #(
  parameter int NUM_VERTICES = 64,
  parameter int MAX_EDGES = 256,
  localparam int CW = $clog2(NUM_VERTICES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CW-1:0]    n,
  dts_in_if.sink           req,
  output dts_pkg::result_t res,
  output logic             res_valid,
  input  logic             res_ready
);

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW = $clog2(MAX_EDGES + 1);
  localparam int SW = VW + 2 * EW + 1;
  localparam int TW = dts_pkg::VTX_W;

  dts_pkg::state_t state, state_next;

  logic                    ld_ok, ld_ok_next;
  logic [VW-1:0]           ld_from, ld_from_next;
  logic [TW-1:0]           ld_to, ld_to_next;
  logic [NW-1:0]           edges, edges_next;
  logic [CW-1:0]           fcount, fcount_next;
  logic                    cycle, cycle_next;
  logic                    drop, drop_next;
  logic [VW-1:0]           sp, sp_next;
  logic [VW-1:0]           s, s_next;
  logic [VW-1:0]           cur_v, cur_v_next;
  logic [EW-1:0]           cur_e, cur_e_next;
  logic [EW-1:0]           cur_tail, cur_tail_next;
  logic                    cur_has, cur_has_next;
  logic [VW-1:0]           t_q, t_q_next;
  logic [NUM_VERTICES-1:0] ht_vld, ht_vld_next;
  logic [NUM_VERTICES-1:0] col_vld, col_vld_next;
  logic                    ht_vq, col_vq;

  logic          ht_we, ht_re;
  logic [VW-1:0] ht_waddr, ht_raddr;
  logic [2*EW-1:0] ht_wdata, ht_rdata;
  logic [EW-1:0] ht_head, ht_tail;

  logic          tgt_we, tgt_re;
  logic [EW-1:0] tgt_waddr, tgt_raddr;
  logic [TW-1:0] tgt_wdata, tgt_rdata;

  logic          lnk_we, lnk_re;
  logic [EW-1:0] lnk_waddr, lnk_raddr;
  logic [EW-1:0] lnk_wdata, lnk_rdata;

  logic          col_we, col_re;
  logic [VW-1:0] col_waddr, col_raddr;
  logic [1:0]    col_wdata, col_rdata, col_val;

  logic          stk_we, stk_re;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  logic          rank_we, rank_re;
  logic [VW-1:0] rank_waddr, rank_raddr;
  logic [CW-1:0] rank_wdata, rank_rdata;

  logic          s_last, t_ok, emit_last;

  assign ht_head = ht_rdata[2*EW-1:EW];
  assign ht_tail = ht_rdata[EW-1:0];
  assign col_val = col_vq ? col_rdata : dts_pkg::COL_WHITE;
  assign s_last  = (CW'(s) == n - CW'(1));
  assign t_ok    = (32'(tgt_rdata) < 32'(n));
  assign emit_last = cycle || s_last;
  assign req.ready = (state == dts_pkg::ST_IDLE);

  dts_ram #(.WIDTH(2 * EW), .DEPTH(NUM_VERTICES)) u_ht_ram (
    .clk, .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata),
    .re(ht_re), .raddr(ht_raddr), .rdata(ht_rdata)
  );

  dts_ram #(.WIDTH(TW), .DEPTH(MAX_EDGES)) u_tgt_ram (
    .clk, .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
    .re(tgt_re), .raddr(tgt_raddr), .rdata(tgt_rdata)
  );

  dts_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_lnk_ram (
    .clk, .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .re(lnk_re), .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  dts_ram #(.WIDTH(2), .DEPTH(NUM_VERTICES)) u_col_ram (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .re(col_re), .raddr(col_raddr), .rdata(col_rdata)
  );

  dts_ram #(.WIDTH(SW), .DEPTH(NUM_VERTICES)) u_stk_ram (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  dts_ram #(.WIDTH(CW), .DEPTH(NUM_VERTICES)) u_rank_ram (
    .clk, .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .re(rank_re), .raddr(rank_raddr), .rdata(rank_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dts_pkg::ST_IDLE;
      edges   <= '0;
      fcount  <= '0;
      cycle   <= 1'b0;
      drop    <= 1'b0;
      sp      <= '0;
      s       <= '0;
      ht_vld  <= '0;
      col_vld <= '0;
    end else begin
      state   <= state_next;
      edges   <= edges_next;
      fcount  <= fcount_next;
      cycle   <= cycle_next;
      drop    <= drop_next;
      sp      <= sp_next;
      s       <= s_next;
      ht_vld  <= ht_vld_next;
      col_vld <= col_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    ld_ok    <= ld_ok_next;
    ld_from  <= ld_from_next;
    ld_to    <= ld_to_next;
    cur_v    <= cur_v_next;
    cur_e    <= cur_e_next;
    cur_tail <= cur_tail_next;
    cur_has  <= cur_has_next;
    t_q      <= t_q_next;
    if (ht_re) begin
      ht_vq <= ht_vld[ht_raddr];
    end
    if (col_re) begin
      col_vq <= col_vld[col_raddr];
    end
  end

  always_comb begin
    state_next    = state;
    ld_ok_next    = ld_ok;
    ld_from_next  = ld_from;
    ld_to_next    = ld_to;
    edges_next    = edges;
    fcount_next   = fcount;
    cycle_next    = cycle;
    drop_next     = drop;
    sp_next       = sp;
    s_next        = s;
    cur_v_next    = cur_v;
    cur_e_next    = cur_e;
    cur_tail_next = cur_tail;
    cur_has_next  = cur_has;
    t_q_next      = t_q;
    ht_vld_next   = ht_vld;
    col_vld_next  = col_vld;

    ht_we = 1'b0;  ht_waddr = ld_from;  ht_wdata = '0;
    ht_re = 1'b0;  ht_raddr = s;
    tgt_we = 1'b0; tgt_waddr = EW'(edges); tgt_wdata = ld_to;
    tgt_re = 1'b0; tgt_raddr = cur_e;
    lnk_we = 1'b0; lnk_waddr = ht_tail; lnk_wdata = EW'(edges);
    lnk_re = 1'b0; lnk_raddr = cur_e;
    col_we = 1'b0; col_waddr = cur_v; col_wdata = dts_pkg::COL_BLACK;
    col_re = 1'b0; col_raddr = s;
    stk_we = 1'b0; stk_waddr = sp; stk_wdata = {cur_v, cur_e, cur_tail, cur_has};
    stk_re = 1'b0; stk_raddr = sp - VW'(1);
    rank_we = 1'b0; rank_waddr = cur_v; rank_wdata = n - fcount;
    rank_re = 1'b0; rank_raddr = s;

    res_valid = 1'b0;
    res.vertex_position = cycle ? '0 : dts_pkg::POS_W'(rank_rdata);
    res.is_last         = emit_last;
    res.has_cycle       = cycle;
    res.edge_dropped    = drop;

    unique case (state)
      dts_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.kind == dts_pkg::KIND_FINISH) begin
            s_next     = '0;
            state_next = dts_pkg::ST_SCAN;
          end else begin
            ht_re        = 1'b1;
            ht_raddr     = VW'(req.from_vertex);
            ld_from_next = VW'(req.from_vertex);
            ld_to_next   = req.to_vertex;
            ld_ok_next   = (32'(req.from_vertex) < 32'(n)) &&
                           (32'(req.to_vertex) < 32'(n)) &&
                           (edges < NW'(MAX_EDGES));
            state_next   = dts_pkg::ST_LOAD;
          end
        end
      end
      dts_pkg::ST_LOAD: begin
        if (ld_ok) begin
          tgt_we = 1'b1;
          ht_we  = 1'b1;
          if (ht_vq) begin
            lnk_we   = 1'b1;
            ht_wdata = {ht_head, EW'(edges)};
          end else begin
            ht_wdata = {EW'(edges), EW'(edges)};
          end
          ht_vld_next[ld_from] = 1'b1;
          edges_next = edges + NW'(1);
        end else begin
          drop_next = 1'b1;
        end
        state_next = dts_pkg::ST_IDLE;
      end
      dts_pkg::ST_SCAN: begin
        col_re     = 1'b1;
        ht_re      = 1'b1;
        state_next = dts_pkg::ST_SCAN_CHK;
      end
      dts_pkg::ST_SCAN_CHK: begin
        if (col_val == dts_pkg::COL_WHITE) begin
          col_we          = 1'b1;
          col_waddr       = s;
          col_wdata       = dts_pkg::COL_GRAY;
          col_vld_next[s] = 1'b1;
          cur_v_next      = s;
          cur_e_next      = ht_head;
          cur_tail_next   = ht_tail;
          cur_has_next    = ht_vq;
          sp_next         = '0;
          state_next      = dts_pkg::ST_STEP;
        end else if (s_last) begin
          s_next     = '0;
          state_next = dts_pkg::ST_EMIT_RD;
        end else begin
          s_next     = s + VW'(1);
          state_next = dts_pkg::ST_SCAN;
        end
      end
      dts_pkg::ST_STEP: begin
        if (cur_has) begin
          tgt_re     = 1'b1;
          lnk_re     = 1'b1;
          state_next = dts_pkg::ST_EDGE;
        end else begin
          // vertex finished
          col_we              = 1'b1;
          col_vld_next[cur_v] = 1'b1;
          rank_we             = 1'b1;
          fcount_next         = fcount + CW'(1);
          if (sp != '0) begin
            stk_re     = 1'b1;
            sp_next    = sp - VW'(1);
            state_next = dts_pkg::ST_POP;
          end else if (s_last) begin
            s_next     = '0;
            state_next = dts_pkg::ST_EMIT_RD;
          end else begin
            s_next     = s + VW'(1);
            state_next = dts_pkg::ST_SCAN;
          end
        end
      end
      dts_pkg::ST_POP: begin
        {cur_v_next, cur_e_next, cur_tail_next, cur_has_next} = stk_rdata;
        state_next = dts_pkg::ST_STEP;
      end
      dts_pkg::ST_EDGE: begin
        cur_has_next = (cur_e != cur_tail);
        cur_e_next   = lnk_rdata;
        t_q_next     = VW'(tgt_rdata);
        if (t_ok) begin
          col_re     = 1'b1;
          col_raddr  = VW'(tgt_rdata);
          ht_re      = 1'b1;
          ht_raddr   = VW'(tgt_rdata);
          state_next = dts_pkg::ST_COLOR;
        end else begin
          drop_next  = 1'b1;
          state_next = dts_pkg::ST_STEP;
        end
      end
      dts_pkg::ST_COLOR: begin
        if (col_val == dts_pkg::COL_WHITE) begin
          // descend into the neighbour
          stk_we            = 1'b1;
          sp_next           = sp + VW'(1);
          col_we            = 1'b1;
          col_waddr         = t_q;
          col_wdata         = dts_pkg::COL_GRAY;
          col_vld_next[t_q] = 1'b1;
          cur_v_next        = t_q;
          cur_e_next        = ht_head;
          cur_tail_next     = ht_tail;
          cur_has_next      = ht_vq;
        end else if (col_val == dts_pkg::COL_GRAY) begin
          cycle_next = 1'b1;
        end
        state_next = dts_pkg::ST_STEP;
      end
      dts_pkg::ST_EMIT_RD: begin
        rank_re    = 1'b1;
        state_next = dts_pkg::ST_EMIT_OUT;
      end
      dts_pkg::ST_EMIT_OUT: begin
        if (res_ready) begin
          res_valid = 1'b1;
          if (emit_last) begin
            state_next = dts_pkg::ST_CLEAR;
          end else begin
            s_next     = s + VW'(1);
            state_next = dts_pkg::ST_EMIT_RD;
          end
        end
      end
      dts_pkg::ST_CLEAR: begin
        ht_vld_next  = '0;
        col_vld_next = '0;
        edges_next   = '0;
        fcount_next  = '0;
        cycle_next   = 1'b0;
        drop_next    = 1'b0;
        s_next       = '0;
        state_next   = dts_pkg::ST_IDLE;
      end
      default: begin
        state_next = dts_pkg::ST_IDLE;
      end
    endcase
  end

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    (state == dts_pkg::ST_IDLE) |-> (sp == '0))
    else $error("stack not empty while idle");

  a_edges_bounded: assert property (@(posedge clk) disable iff (rst)
    (edges <= NW'(MAX_EDGES)))
    else $error("edge count beyond capacity");

  a_finish_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == dts_pkg::ST_STEP) |-> (fcount <= n))
    else $error("more vertices finished than exist");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == dts_pkg::ST_CLEAR) |=> (ht_vld == '0 && col_vld == '0 && edges == '0))
    else $error("stores not cleared after run");

endmodule

/* hdl/dfs_topological_sort.sv */
// ----------------------------------------------------------------------------
// dfs_topological_sort
// depth-first topological sort of a directed graph with cycle detection
// ----------------------------------------------------------------------------
// Each edge request does a head/tail lookup, then a list append. A finish
// request walks the graph from vertex 0 upward with an explicit stack held
// in block ram: a colour and head/tail read per vertex scanned, an edge
// fetch, colour fetch and push or skip per edge followed, a colour and rank
// write per vertex finished, then a rank read and output load per result
// and a clear of the valid bits of the head/tail and colour stores. The walk
// is set by the registered reads of the edge and colour memories. The acyclic
// case returns one result per vertex with its 1-based topological position;
// a cycle returns a single result with has_cycle set.
// ----------------------------------------------------------------------------
module dfs_topological_sort #(
  parameter int NUM_VERTICES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dts_pkg::CFG_W-1:0] cfg_wdata,
  dts_in_if.sink                    req,
  dts_out_if.source                 rsp
);

  localparam int CW = $clog2(NUM_VERTICES + 1);

  logic [dts_pkg::CFG_W-1:0] vertex_count;
  logic [CW-1:0]             n;
  dts_pkg::result_t          res, out_q;
  logic                      res_valid, res_ready, out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= dts_pkg::VC_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (vertex_count == '0) begin
      n = CW'(1);
    end else if (32'(vertex_count) > NUM_VERTICES) begin
      n = CW'(NUM_VERTICES);
    end else begin
      n = CW'(vertex_count);
    end
  end

  dts_engine #(.NUM_VERTICES(NUM_VERTICES), .MAX_EDGES(MAX_EDGES)) u_engine (
    .clk,
    .rst,
    .n,
    .req,
    .res,
    .res_valid,
    .res_ready
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.vertex_position = out_q.vertex_position;
  assign rsp.is_last         = out_q.is_last;
  assign rsp.has_cycle       = out_q.has_cycle;
  assign rsp.edge_dropped    = out_q.edge_dropped;

endmodule

/* tb/sv/dfs_topological_sort_tb.sv */
// ----------------------------------------------------------------------------
// dfs_topological_sort_tb
// self-checking bench for the depth-first topological sorter: loads edge
// and finish requests under random idling, gets each expected result from
// a behavioural model or the directed table and compares field by field
// ----------------------------------------------------------------------------
module dfs_topological_sort_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;
  localparam int ME = 256;
  localparam int NULL_LINK = ME;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 40;

  typedef struct {
    logic                      kind;
    logic [dts_pkg::VTX_W-1:0] from_vertex;
    logic [dts_pkg::VTX_W-1:0] to_vertex;
    bit                        typed;
    dts_pkg::result_t          typed_rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [dts_pkg::CFG_W-1:0] cfg_wdata = '0;

  dts_in_if req ();
  dts_out_if rsp ();

  dfs_topological_sort dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sorter state
  int vcount;
  int e_target [ME];
  int e_link [ME];
  int l_head [NV];
  int l_tail [NV];
  logic [1:0] colour [NV];
  int stk_v [NV];
  int stk_e [NV];
  int fin_order [NV];
  int fin_count;
  int n_edges;
  bit cyc_seen;
  bit drp_seen;

  dts_pkg::result_t pending_rsp [$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;

  function automatic void clear_graph();
    for (int i = 0; i < NV; i++) begin
      l_head[i] = NULL_LINK;
      l_tail[i] = NULL_LINK;
      colour[i] = dts_pkg::COL_WHITE;
    end
    fin_count = 0;
    n_edges = 0;
    cyc_seen = 0;
    drp_seen = 0;
  endfunction

  function automatic int live_vertices();
    if (vcount < 1) return 1;
    if (vcount > NV) return NV;
    return vcount;
  endfunction

  function automatic void depth_first_walk(int n);
    int sp, top, v, e, t;
    for (int s = 0; s < n; s++) begin
      if (colour[s] != dts_pkg::COL_WHITE) continue;
      colour[s] = dts_pkg::COL_GRAY;
      stk_v[0] = s;
      stk_e[0] = l_head[s];
      sp = 1;
      while (sp > 0) begin
        top = sp - 1;
        v = stk_v[top];
        e = stk_e[top];
        if (e >= ME) begin
          colour[v] = dts_pkg::COL_BLACK;
          if (fin_count < NV) begin
            fin_order[fin_count] = v;
            fin_count++;
          end
          sp--;
        end else begin
          t = e_target[e];
          stk_e[top] = e_link[e];
          if (t >= n) drp_seen = 1;
          else if (colour[t] == dts_pkg::COL_WHITE) begin
            if (sp < NV) begin
              colour[t] = dts_pkg::COL_GRAY;
              stk_v[sp] = t;
              stk_e[sp] = l_head[t];
              sp++;
            end
          end else if (colour[t] == dts_pkg::COL_GRAY) cyc_seen = 1;
        end
      end
    end
  endfunction

  function automatic void predict_order(logic kind, int fv, int tv);
    int n, e;
    int rank [NV];
    dts_pkg::result_t r;
    n = live_vertices();
    if (kind == dts_pkg::KIND_EDGE) begin
      if (fv >= n || tv >= n || n_edges >= ME) begin
        drp_seen = 1;
        return;
      end
      e = n_edges++;
      e_target[e] = tv;
      e_link[e] = NULL_LINK;
      if (l_head[fv] == NULL_LINK) l_head[fv] = e;
      else e_link[l_tail[fv]] = e;
      l_tail[fv] = e;
      return;
    end
    depth_first_walk(n);
    if (cyc_seen) begin
      r.vertex_position = '0;
      r.is_last = 1'b1;
      r.has_cycle = 1'b1;
      r.edge_dropped = drp_seen;
      pending_rsp.push_back(r);
    end else begin
      for (int i = 0; i < NV; i++) rank[i] = 0;
      for (int k = 0; k < fin_count && k < n; k++) rank[fin_order[k]] = n - k;
      for (int v = 0; v < n; v++) begin
        r.vertex_position = rank[v][dts_pkg::POS_W-1:0];
        r.is_last = (v + 1 == n);
        r.has_cycle = 1'b0;
        r.edge_dropped = drp_seen;
        pending_rsp.push_back(r);
      end
    end
    clear_graph();
  endfunction

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected result: got %p", $time,
                   dts_pkg::result_t'({rsp.vertex_position, rsp.is_last,
                                       rsp.has_cycle, rsp.edge_dropped}));
          errors++;
        end else begin
          dts_pkg::result_t want;
          want = pending_rsp.pop_front();
          if (rsp.vertex_position !== want.vertex_position) begin
            $display("%0t vertex_position: expected %0d actual %0d", $time,
                     want.vertex_position, rsp.vertex_position);
            errors++;
          end
          if (rsp.is_last !== want.is_last) begin
            $display("%0t is_last: expected %0b actual %0b", $time,
                     want.is_last, rsp.is_last);
            errors++;
          end
          if (rsp.has_cycle !== want.has_cycle) begin
            $display("%0t has_cycle: expected %0b actual %0b", $time,
                     want.has_cycle, rsp.has_cycle);
            errors++;
          end
          if (rsp.edge_dropped !== want.edge_dropped) begin
            $display("%0t edge_dropped: expected %0b actual %0b", $time,
                     want.edge_dropped, rsp.edge_dropped);
            errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(logic kind, int fv, int tv);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= kind;
    req.from_vertex <= fv[dts_pkg::VTX_W-1:0];
    req.to_vertex <= tv[dts_pkg::VTX_W-1:0];
    do @(posedge clk); while (!req.ready);
    predict_order(kind, fv, tv);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(int value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value[dts_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = value;
  endtask

  // random graph with forward edges unless cycles are allowed, plus occasional noise edges
  task automatic random_graph(int n, int edges, bit allow_cycle);
    int a, b;
    for (int i = 0; i < edges; i++) begin
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      if (!allow_cycle && a > b) begin
        int t;
        t = a; a = b; b = t;
      end
      if (!allow_cycle && a == b) b = (b + 1 < n) ? b + 1 : b;
      if (!allow_cycle && a == b) continue;
      if ($urandom_range(19) == 0) begin
        a = $urandom_range(63);
        b = $urandom_range(63);
      end
      send_request(dts_pkg::KIND_EDGE, a, b);
    end
    send_request(dts_pkg::KIND_FINISH, $urandom_range(63), $urandom_range(63));
  endtask

  stim_row_t directed [] = '{
    '{dts_pkg::KIND_FINISH, 6'd0, 6'd0, 1'b0, '0},
    '{dts_pkg::KIND_EDGE, 6'd0, 6'd0, 1'b0, '0},
    '{dts_pkg::KIND_FINISH, 6'd63, 6'd63, 1'b1, '{7'd0, 1'b1, 1'b1, 1'b0}},
    '{dts_pkg::KIND_EDGE, 6'd63, 6'd0, 1'b0, '0},
    '{dts_pkg::KIND_EDGE, 6'd0, 6'd63, 1'b0, '0},
    '{dts_pkg::KIND_EDGE, 6'd5, 6'd2, 1'b0, '0},
    '{dts_pkg::KIND_FINISH, 6'd0, 6'd0, 1'b0, '0},
    '{dts_pkg::KIND_EDGE, 6'd1, 6'd2, 1'b0, '0},
    '{dts_pkg::KIND_EDGE, 6'd2, 6'd3, 1'b0, '0},
    '{dts_pkg::KIND_EDGE, 6'd3, 6'd1, 1'b0, '0},
    '{dts_pkg::KIND_EDGE, 6'd42, 6'd21, 1'b0, '0},
    '{dts_pkg::KIND_FINISH, 6'd21, 6'd42, 1'b0, '0}
  };

  initial begin
    int n;
    req.valid = 1'b0;
    req.kind = dts_pkg::KIND_EDGE;
    req.from_vertex = '0;
    req.to_vertex = '0;
    vcount = dts_pkg::VC_RESET;
    clear_graph();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].typed) begin
        pending_rsp.push_back(directed[i].typed_rsp);
        clear_graph();
        req.valid <= 1'b1;
        req.kind <= directed[i].kind;
        req.from_vertex <= directed[i].from_vertex;
        req.to_vertex <= directed[i].to_vertex;
        do @(posedge clk); while (!req.ready);
      end else begin
        send_request(directed[i].kind, directed[i].from_vertex, directed[i].to_vertex);
      end
    end

    // extreme counts, out-of-range counts, lowered count after load
    write_count(1);
    send_request(dts_pkg::KIND_EDGE, 0, 0);
    send_request(dts_pkg::KIND_EDGE, 0, 1);
    send_request(dts_pkg::KIND_FINISH, 0, 0);
    write_count(0);
    send_request(dts_pkg::KIND_FINISH, 0, 0);
    write_count(127);
    send_request(dts_pkg::KIND_EDGE, 62, 63);
    send_request(dts_pkg::KIND_FINISH, 0, 0);
    write_count(10);
    send_request(dts_pkg::KIND_EDGE, 0, 8);
    send_request(dts_pkg::KIND_EDGE, 8, 9);
    drain_results();
    write_count(9);
    send_request(dts_pkg::KIND_FINISH, 0, 0);
    write_count(2);
    send_request(dts_pkg::KIND_EDGE, 1, 0);
    send_request(dts_pkg::KIND_FINISH, 0, 0);

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 48 : 18) : 0;
      recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 48 : 18) : 0;
      n = (phase == 3) ? 64 : $urandom_range(3, 16);
      write_count(n);
      for (int g = 0; g < 5; g++) random_graph(n, $urandom_range(2, 12), $urandom_range(3) == 0);
    end
    send_idle = 0;
    recv_stall = 0;
    drain_results();

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
